### rtl/lpht_pkg.sv
// shared types and constants for the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int KEY_W = 31;
    localparam int VAL_W = 32;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NEW     = 3'd2,
        ST_UPDATED = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic                    req_type;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp;

endpackage

### rtl/lpht_front.sv
// front end: takes request beats and works out the home slot
`timescale 1ns / 1ps

module lpht_front
    import lpht_pkg::*;
#(
    parameter int SLOTS  = 128,
    parameter int SLOT_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_req                       i_req,
    output logic                       o_q_valid,
    input  logic                       i_q_full,
    output logic [$bits(t_req)+SLOT_W-1:0] o_q_data
);

    localparam bit              IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(SLOTS);
    // floor of 2^32 / SLOTS, quotient estimate comes out low by at most one
    localparam logic [31:0]     RECIP   = 32'(64'h1_0000_0000 / SLOTS);
    localparam int              PROD_W  = KEY_W + 32;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } t_fstate;

    t_fstate               r_state;
    t_req                  r_req;
    logic [SLOT_W-1:0]     r_rem;
    logic [SLOT_W:0]       r_quo;
    logic [PROD_W-1:0]     prod;
    logic [SLOT_W:0]       quo_mul;
    logic [SLOT_W-1:0]     mod_next;
    logic [SLOT_W:0]       rem;
    logic                  accept;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == F_IDLE);
    assign o_q_valid = (r_state == F_PUSH);
    assign o_q_data  = {r_req, r_rem};

    // reciprocal multiply for the quotient, then only low bits are needed:
    // key - quotient * SLOTS lies below 2 * SLOTS, one conditional subtract ends it
    assign prod     = PROD_W'(r_req.key) * PROD_W'(RECIP);
    assign quo_mul  = r_quo * SLOTS_X;
    assign rem      = r_req.key[SLOT_W:0] - quo_mul;
    assign mod_next = (rem >= SLOTS_X) ? SLOT_W'(rem - SLOTS_X) : rem[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_req <= i_req;
                        if (IS_POW2) begin
                            r_rem   <= i_req.key[SLOT_W-1:0];
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_MUL;
                        end
                    end
                end
                F_MUL: begin
                    r_quo   <= prod[32+SLOT_W:32];
                    r_state <= F_MOD;
                end
                F_MOD: begin
                    r_rem   <= mod_next;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/lpht_fifo.sv
// two entry queue between the front end and the probe engine
`timescale 1ns / 1ps

module lpht_fifo #(
    parameter int WIDTH = 70
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/lpht_back.sv
// probe engine: slot memory, linear probe walk and result register
`timescale 1ns / 1ps

module lpht_back
    import lpht_pkg::*;
#(
    parameter int SLOTS  = 128,
    parameter int SLOT_W = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [$bits(t_req)+SLOT_W-1:0] i_q_data,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_rsp                           o_rsp
);

    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } t_state;

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    t_slot             mem [SLOTS];
    t_slot             r_rd;
    t_state            r_state;
    t_req              r_req;
    logic [SLOT_W-1:0] r_pos;
    logic [SLOT_W-1:0] r_cnt;
    logic              r_out_valid;
    t_rsp              r_out;

    t_req              q_req;
    logic [SLOT_W-1:0] q_home;
    logic [SLOT_W-1:0] pos_next;
    logic [SLOT_W-1:0] rd_addr;
    logic              slot_hit;
    logic              slot_empty;
    logic              done;
    logic              out_free;
    logic              finish;
    logic              mem_we;
    t_slot             mem_wd;
    t_rsp              res;

    assign {q_req, q_home} = i_q_data;

    assign slot_hit   = r_rd.valid && (r_rd.key == r_req.key);
    assign slot_empty = !r_rd.valid;
    assign done       = slot_hit || slot_empty || (r_cnt == LAST);
    assign out_free   = !r_out_valid || i_ready;
    assign finish     = (r_state == S_CHECK) && done && out_free;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign pos_next   = (r_pos == LAST) ? '0 : r_pos + 1'b1;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = q_home;
            S_CHECK: rd_addr = done ? r_pos : pos_next;
            default: rd_addr = r_pos;
        endcase
    end

    // result and table update for the slot under the probe, and the clearing-pass writes
    always_comb begin
        res.status     = ST_FULL;
        res.read_value = '0;
        mem_we         = 1'b0;
        mem_wd         = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (slot_hit || slot_empty) begin
            if (r_req.req_type == REQ_LOOKUP) begin
                res.status     = slot_hit ? ST_HIT : ST_MISS;
                res.read_value = slot_hit ? r_rd.value : MISS_VALUE;
            end else begin
                res.status   = slot_hit ? ST_UPDATED : ST_NEW;
                mem_we       = finish;
                mem_wd.valid = 1'b1;
                mem_wd.key   = r_req.key;
                mem_wd.value = r_req.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_pos <= pos_next;
                    if (r_pos == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= q_req;
                        r_pos   <= q_home;
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!done) begin
                        r_pos <= pos_next;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (finish) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_q_pop)
        else $error("queue popped during clearing pass");

    a_probe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !done) |=>
            (r_state == S_CHECK && r_cnt == $past(r_cnt) + 1'b1 && r_pos == $past(pos_next)))
        else $error("probe walk did not advance");

    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_CHECK) |=> (r_out_valid && r_out.status != ST_FULL))
        else $error("table written without a result beat");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && res.status == ST_FULL) |-> (r_cnt == LAST && !mem_we))
        else $error("table full reported before a full sweep");

endmodule

### rtl/linear_probe_hash_table.sv
// top level of the linear probing hash table: front end, queue, probe engine
`timescale 1ns / 1ps

// path: the front end finds the home slot, directly when SLOTS is a power of two, else
//   by a reciprocal multiply step and a reduce step; the queue then feeds the probe walk
// flow: front end and probe engine each take a new beat only when done with the last
//   one; the slower side sets the rate
// reset: synchronous active low; then a clearing pass over all slots marks them empty,
//   requests are taken into the queue meanwhile but probing waits for it to end

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    // slot index width, also the home slot carried with each request
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int Q_W    = $bits(t_req) + SLOT_W;

    // front end to queue
    logic           push_valid;
    logic           q_full;
    logic [Q_W-1:0] push_data;

    // queue to probe engine
    logic           q_valid;
    logic           q_pop;
    logic [Q_W-1:0] q_data;

    // request beats are classified here: home slot is key modulo SLOTS
    lpht_front #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_q_valid (push_valid),
        .i_q_full  (q_full),
        .o_q_data  (push_data)
    );

    // decouples the remainder unit from the probe walk
    lpht_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    // probe walk over the slot memory, one slot per cycle, registered result beat
    lpht_back #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

endmodule

### verif/linear_probe_hash_table_test.sv
// self-checking testbench for the linear probing hash table
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int TBL_SLOTS   = 128;
    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 300;
    localparam int POOL_SIZE   = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_req i_req   = '0;
    logic o_ready;
    logic o_valid;
    t_rsp o_rsp;

    // shadow copy of the table, updated as each request beat is accepted
    logic                    tbl_valid [TBL_SLOTS];
    logic [KEY_W-1:0]        tbl_key   [TBL_SLOTS];
    logic signed [VAL_W-1:0] tbl_value [TBL_SLOTS];
    int                      tbl_used;
    logic [KEY_W-1:0]        stored_keys [$];

    t_rsp             expected_rsp_q [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // shared knobs between the test tasks and the handshake processes
    bit no_gaps;
    int hold_request;

    int fail_count;
    int idle_cycles;
    int n_lookup;
    int n_insert;
    int n_status [5];

    linear_probe_hash_table #(
        .SLOTS (TBL_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // walk from the home slot: stop on the key, an empty slot or a full sweep
    function automatic t_rsp probe_table(t_req req);
        t_rsp rsp;
        int   pos;
        int   found;
        int   n;
        rsp.status     = ST_FULL;
        rsp.read_value = '0;
        pos   = int'(req.key % TBL_SLOTS);
        found = 2;
        for (n = 0; n < TBL_SLOTS && found == 2; n++) begin
            if (!tbl_valid[pos]) begin
                found = 1;
            end else if (tbl_key[pos] == req.key) begin
                found = 0;
            end else begin
                pos = (pos + 1) % TBL_SLOTS;
            end
        end
        if (found == 2) begin
            return rsp;
        end
        if (req.req_type == REQ_LOOKUP) begin
            if (found == 0) begin
                rsp.status     = ST_HIT;
                rsp.read_value = tbl_value[pos];
            end else begin
                rsp.status     = ST_MISS;
                rsp.read_value = MISS_VALUE;
            end
        end else begin
            if (found == 0) begin
                rsp.status = ST_UPDATED;
            end else begin
                rsp.status = ST_NEW;
                tbl_used++;
                stored_keys.push_back(req.key);
            end
            tbl_valid[pos] = 1'b1;
            tbl_key[pos]   = req.key;
            tbl_value[pos] = req.value;
        end
        return rsp;
    endfunction

    // random key whose home slot lies in 0 .. low_max, upper bits random
    function automatic logic [KEY_W-1:0] rand_key(int low_max);
        logic [KEY_W-1:0] k;
        k      = KEY_W'($urandom);
        k[6:0] = 7'($urandom_range(0, low_max));
        return k;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        return VAL_W'($urandom);
    endfunction

    // offer one request beat; valid stays up across back-to-back beats
    task automatic send_req(input logic rt, input logic [KEY_W-1:0] k,
                            input logic signed [VAL_W-1:0] v);
        t_req req;
        int   gap;
        req.req_type = rt;
        req.key      = k;
        req.value    = v;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (!o_ready);
        expected_rsp_q.push_back(probe_table(req));
        if (rt == REQ_INSERT) n_insert++;
        else n_lookup++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // one random beat against the key pool, with some noise lookups
    task automatic send_pool_mix();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_req(REQ_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_value());
        end else if (pick < 85) begin
            send_req(REQ_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_value());
        end else begin
            send_req(REQ_LOOKUP, rand_key(127), rand_value());
        end
    endtask

    task automatic test_empty_lookups();
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_LOOKUP, '1, 32'sh7FFF_FFFF);
        send_req(REQ_LOOKUP, rand_key(127), rand_value());
        wait_drain();
    endtask

    task automatic test_insert_update();
        send_req(REQ_INSERT, '0, 32'sh7FFF_FFFF);
        send_req(REQ_INSERT, '1, 32'sh8000_0000);
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_LOOKUP, '1, '0);
        send_req(REQ_INSERT, '0, -32'sd1);
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_INSERT, '0, '0);
        send_req(REQ_LOOKUP, '0, '1);
        wait_drain();
    endtask

    // keys sharing the last home slot spill over the end and wrap to slot 0
    task automatic test_collision_wrap();
        send_req(REQ_INSERT, 31'd127, 32'sd127);
        send_req(REQ_INSERT, 31'd255, 32'sd255);
        send_req(REQ_INSERT, 31'd383, 32'sd383);
        send_req(REQ_LOOKUP, 31'd383, '0);
        send_req(REQ_LOOKUP, 31'd255, '0);
        send_req(REQ_LOOKUP, 31'd511, '0);
        send_req(REQ_INSERT, 31'd255, -32'sd255);
        send_req(REQ_LOOKUP, 31'd255, '0);
        send_req(REQ_LOOKUP, 31'd1, '0);
        wait_drain();
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = ($urandom_range(0, 1) != 0) ? rand_key(31) : rand_key(127);
        end
        for (i = 0; i < 760; i++) begin
            // back-to-back stretch in the middle of the run
            no_gaps = (i >= 300 && i < 420);
            send_pool_mix();
        end
        no_gaps = 1'b0;
        wait_drain();
    endtask

    // receiver stalls long while the sender keeps offering beats
    task automatic test_backpressure();
        int i;
        hold_request = HOLD_CYCLES;
        no_gaps      = 1'b1;
        for (i = 0; i < 40; i++) begin
            send_pool_mix();
        end
        no_gaps = 1'b0;
        wait_drain();
    endtask

    task automatic test_fill_table();
        while (tbl_used < TBL_SLOTS) begin
            send_req(REQ_INSERT, rand_key(127), rand_value());
        end
        // full sweep without a match or an empty slot, both request kinds
        send_req(REQ_INSERT, rand_key(127), rand_value());
        send_req(REQ_LOOKUP, rand_key(127), rand_value());
        wait_drain();
    endtask

    task automatic test_full_table();
        int i;
        int pick;
        for (i = 0; i < 200; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_req(REQ_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                         rand_value());
            end else if (pick < 70) begin
                send_req(REQ_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                         rand_value());
            end else begin
                send_req(pick[0], rand_key(127), rand_value());
            end
        end
        wait_drain();
    endtask

    // receiver: random ready gaps, plus one long hold on request
    initial begin : receiver
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result beat with nothing expected: status %0d value %0d",
                           o_rsp.status, o_rsp.read_value);
                    fail_count++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (o_rsp.status !== exp_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_rsp.status, o_rsp.status);
                        fail_count++;
                    end
                    if (o_rsp.read_value !== exp_rsp.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               exp_rsp.read_value, o_rsp.read_value);
                        fail_count++;
                    end
                    if (int'(exp_rsp.status) < 5) n_status[int'(exp_rsp.status)]++;
                end
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    initial begin : main
        int i;
        for (i = 0; i < TBL_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        tbl_used     = 0;
        no_gaps      = 1'b0;
        hold_request = 0;
        fail_count   = 0;
        n_lookup     = 0;
        n_insert     = 0;
        for (i = 0; i < 5; i++) n_status[i] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lookups();
        test_insert_update();
        test_collision_wrap();
        test_random_mix();
        test_backpressure();
        test_fill_table();
        test_full_table();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d lookups and %0d inserts, filling the table to a full sweep",
                 n_lookup, n_insert);
        $display("outcomes: %0d hit, %0d miss, %0d new, %0d updated, %0d full",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        if (fail_count == 0 && expected_rsp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (expected_rsp_q.size() != 0) begin
                $error("%0d expected results never arrived", expected_rsp_q.size());
            end
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
